### rtl/core/mis_pkg.sv
// shared constants and types for the minimum image separation block
package mis_pkg;

  localparam int NUM_LANES = 3;
  localparam int COORD_W   = 32;
  localparam int LEN_W     = 31;
  localparam int SEP_W     = COORD_W + 1;
  localparam int MAG_W     = COORD_W;
  localparam int NUM_W     = MAG_W + 2;
  localparam int REM_W     = LEN_W + 1;
  localparam int DIV_STEPS = NUM_W;
  localparam int SQ_W      = 2 * MAG_W;

  localparam int LANE_LAT  = DIV_STEPS + 6;
  localparam int MERGE_LAT = 2;
  localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT;

  localparam int Q_DEPTH = 64;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = Q_AW + 1;

  localparam int IN_W    = 2 * NUM_LANES * COORD_W;
  localparam int RES_W   = NUM_LANES * SEP_W + SQ_W + NUM_LANES;
  localparam int OUT_W   = ((RES_W + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - RES_W;

  localparam int ADDR_W = 5;
  localparam int CFG_W  = 32;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(65536);

  typedef enum logic [2:0] {
    REG_BOX_X = 3'd0,
    REG_BOX_Y = 3'd1,
    REG_BOX_Z = 3'd2,
    REG_PER_X = 3'd3,
    REG_PER_Y = 3'd4,
    REG_PER_Z = 3'd5
  } reg_idx_t;

  // one divider stage of a lane
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [LEN_W-1:0] len;
    logic [SEP_W-1:0] d;
    logic [MAG_W-1:0] mag;
    logic             flag;
    logic             bypass;
  } div_t;

  typedef struct packed {
    logic [SEP_W-1:0] sep;
    logic             wrapped;
    logic [SQ_W-1:0]  sq;
  } lane_out_t;

  typedef struct packed {
    logic [NUM_LANES-1:0]            wrapped;
    logic [SQ_W-1:0]                 dist_sq;
    logic [NUM_LANES-1:0][SEP_W-1:0] sep;
  } res_t;

endpackage

### rtl/core/mis_lane.sv
// one axis: difference, pipelined nearest-multiple wrap and square
module mis_lane import mis_pkg::*; (
  input  logic               clk,
  input  logic [COORD_W-1:0] first,
  input  logic [COORD_W-1:0] second,
  input  logic [LEN_W-1:0]   len,
  input  logic               periodic,
  output lane_out_t          res
);

  // stage a: raw difference
  logic [SEP_W-1:0] a_d;
  logic [LEN_W-1:0] a_len;
  logic             a_bypass;

  always_ff @(posedge clk) begin
    a_d      <= {second[COORD_W-1], second} - {first[COORD_W-1], first};
    a_len    <= len;
    a_bypass <= !periodic || (len == '0);
  end

  // stage b: magnitude
  logic [SEP_W-1:0] a_neg;
  logic [SEP_W-1:0] b_d;
  logic [MAG_W-1:0] b_mag;
  logic [LEN_W-1:0] b_len;
  logic             b_bypass;

  assign a_neg = -a_d;

  always_ff @(posedge clk) begin
    b_d      <= a_d;
    b_mag    <= a_d[SEP_W-1] ? a_neg[MAG_W-1:0] : a_d[MAG_W-1:0];
    b_len    <= a_len;
    b_bypass <= a_bypass;
  end

  // stage c: dividend 2*mag + len over divisor 2*len, remainder only
  div_t stg      [0:DIV_STEPS];
  div_t stg_next [1:DIV_STEPS];

  // restoring division, one dividend bit per stage
  always_comb begin
    logic [REM_W:0] t;
    logic [REM_W:0] dv;
    logic [REM_W:0] diff;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      t               = {stg[k-1].rem, stg[k-1].num[DIV_STEPS-k]};
      dv              = {1'b0, stg[k-1].len, 1'b0};
      diff            = t - dv;
      stg_next[k]     = stg[k-1];
      stg_next[k].rem = (t >= dv) ? diff[REM_W-1:0] : t[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    stg[0].rem    <= '0;
    stg[0].num    <= {1'b0, b_mag, 1'b0} + {3'b0, b_len};
    stg[0].len    <= b_len;
    stg[0].d      <= b_d;
    stg[0].mag    <= b_mag;
    stg[0].flag   <= !b_bypass && ({b_mag, 1'b0} >= {2'b0, b_len});
    stg[0].bypass <= b_bypass;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      stg[k] <= stg_next[k];
    end
  end

  // stage e: r = (rem - len) / 2, exact since the difference is even
  logic [SEP_W-1:0] rl;
  logic [SEP_W-1:0] lr;
  logic [MAG_W-1:0] e_r;
  logic [LEN_W-1:0] e_abs;
  logic [SEP_W-1:0] e_d;
  logic [MAG_W-1:0] e_mag;
  logic             e_flag;
  logic             e_bypass;

  assign rl = {1'b0, stg[DIV_STEPS].rem} - {2'b0, stg[DIV_STEPS].len};
  assign lr = {2'b0, stg[DIV_STEPS].len} - {1'b0, stg[DIV_STEPS].rem};

  always_ff @(posedge clk) begin
    e_r      <= rl[SEP_W-1:1];
    e_abs    <= rl[SEP_W-1] ? lr[LEN_W:1] : rl[LEN_W:1];
    e_d      <= stg[DIV_STEPS].d;
    e_mag    <= stg[DIV_STEPS].mag;
    e_flag   <= stg[DIV_STEPS].flag;
    e_bypass <= stg[DIV_STEPS].bypass;
  end

  // stage f: restore the sign of the raw difference, or pass the difference through on bypass
  logic [SEP_W-1:0] r_ext;
  logic [SEP_W-1:0] r_neg;
  logic [SEP_W-1:0] f_sep;
  logic [MAG_W-1:0] f_sqm;
  logic             f_flag;

  assign r_ext = {e_r[MAG_W-1], e_r};
  assign r_neg = -r_ext;

  always_ff @(posedge clk) begin
    f_sep  <= e_bypass ? e_d : (e_d[SEP_W-1] ? r_neg : r_ext);
    f_sqm  <= e_bypass ? e_mag : {1'b0, e_abs};
    f_flag <= e_flag;
  end

  // stage g: square
  logic [SQ_W-1:0] prod;

  assign prod = f_sqm * f_sqm;

  always_ff @(posedge clk) begin
    res.sep     <= f_sep;
    res.wrapped <= f_flag;
    res.sq      <= prod;
  end

endmodule

### rtl/core/mis_merge.sv
// merges the lanes: saturating sum of squares, separations and wrap flags
module mis_merge import mis_pkg::*; (
  input  logic      clk,
  input  lane_out_t lanes [NUM_LANES],
  output res_t      res
);

  logic [SQ_W:0]                   m_sum01;
  logic [SQ_W-1:0]                 m_sq2;
  logic [NUM_LANES-1:0][SEP_W-1:0] m_sep;
  logic [NUM_LANES-1:0]            m_wr;
  logic [SQ_W+1:0]                 total;

  always_ff @(posedge clk) begin
    m_sum01 <= {1'b0, lanes[0].sq} + {1'b0, lanes[1].sq};
    m_sq2   <= lanes[2].sq;
    for (int i = 0; i < NUM_LANES; i++) begin
      m_sep[i] <= lanes[i].sep;
      m_wr[i]  <= lanes[i].wrapped;
    end
  end

  assign total = {1'b0, m_sum01} + {2'b0, m_sq2};

  always_ff @(posedge clk) begin
    res.sep     <= m_sep;
    res.wrapped <= m_wr;
    res.dist_sq <= (total[SQ_W+1:SQ_W] != 2'b0) ? '1 : total[SQ_W-1:0];
  end

endmodule

### rtl/core/mis_outq.sv
// result queue with registered read and an output register
module mis_outq import mis_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  res_t wr_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  res_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] cnt;
  logic            rd_valid;
  res_t            rd_data;
  logic            out_load;
  logic            rd_issue;

  assign out_load = rd_valid && (!out_valid || out_ready);
  assign rd_issue = (cnt != '0) && (!rd_valid || out_load);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
    if (rd_issue) begin
      rd_data <= mem[rd_ptr];
    end
    if (out_load) begin
      out_data <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      cnt       <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_issue) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      cnt <= cnt + Q_CW'(wr_en) - Q_CW'(rd_issue);
      if (rd_issue) begin
        rd_valid <= 1'b1;
      end else if (out_load) begin
        rd_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/minimum_image_separation.sv
// top level: minimum image separation of atom pairs, three axis lanes and a merge stage
// Takes one atom pair per clock while s_tready is high and returns the wrapped
// per-axis separations, the saturating squared distance and per-axis wrap flags.
// Each axis lane runs a 34-stage pipelined remainder divider for the
// nearest-multiple wrap, then a 32x32 square; a merge stage adds the squares.
// Up to 64 pairs may be in flight, set by the depth of the result queue;
// s_tready drops only when that many results are pending. The user must write
// box lengths and periodic enables over the register port only while no pair
// is in flight; the block itself does not enforce it.
module minimum_image_separation import mis_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // s_tdata: first_x, first_y, first_z, second_x, second_y, second_z (32 bits each)
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,
  // m_tdata: sep_x, sep_y, sep_z (33 bits each), dist_sq (64), wrapped_x,
  // wrapped_y, wrapped_z, two zero bits
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready
);

  logic [LEN_W-1:0]     box_len [NUM_LANES];
  logic [NUM_LANES-1:0] periodic;
  reg_idx_t             reg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        box_len[i] <= LEN_RESET;
      end
      periodic <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BOX_X: box_len[0]  <= pwdata[LEN_W-1:0];
        REG_BOX_Y: box_len[1]  <= pwdata[LEN_W-1:0];
        REG_BOX_Z: box_len[2]  <= pwdata[LEN_W-1:0];
        REG_PER_X: periodic[0] <= pwdata[0];
        REG_PER_Y: periodic[1] <= pwdata[0];
        REG_PER_Z: periodic[2] <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BOX_X: prdata = {{(CFG_W-LEN_W){1'b0}}, box_len[0]};
      REG_BOX_Y: prdata = {{(CFG_W-LEN_W){1'b0}}, box_len[1]};
      REG_BOX_Z: prdata = {{(CFG_W-LEN_W){1'b0}}, box_len[2]};
      REG_PER_X: prdata = {{(CFG_W-1){1'b0}}, periodic[0]};
      REG_PER_Y: prdata = {{(CFG_W-1){1'b0}}, periodic[1]};
      REG_PER_Z: prdata = {{(CFG_W-1){1'b0}}, periodic[2]};
      default:   prdata = '0;
    endcase
  end

  // credit count: pairs taken whose results have not left yet
  logic            in_xfer;
  logic            out_xfer;
  logic [Q_CW-1:0] pending;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;
  assign s_tready = (pending < Q_CW'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + Q_CW'(in_xfer) - Q_CW'(out_xfer);
    end
  end

  logic [PIPE_LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LAT-2:0], in_xfer};
    end
  end

  lane_out_t lanes [NUM_LANES];

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    mis_lane u_lane (
      .clk      (clk),
      .first    (s_tdata[i*COORD_W +: COORD_W]),
      .second   (s_tdata[(i+NUM_LANES)*COORD_W +: COORD_W]),
      .len      (box_len[i]),
      .periodic (periodic[i]),
      .res      (lanes[i])
    );
  end

  res_t merged;
  res_t q_data;

  mis_merge u_merge (
    .clk   (clk),
    .lanes (lanes),
    .res   (merged)
  );

  mis_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (vld[PIPE_LAT-1]),
    .wr_data   (merged),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (q_data)
  );

  assign m_tdata = {{OUT_PAD{1'b0}}, q_data};

endmodule

### tb/sv/minimum_image_separation_tb.sv
// testbench for the minimum image separation block: random and directed pairs, scoreboard check
`timescale 1ns / 100ps

module minimum_image_separation_tb;
  import mis_pkg::*;

  localparam int NUM_REGS    = 6;
  localparam int DIST_LSB    = NUM_LANES * SEP_W;
  localparam int WRAP_LSB    = DIST_LSB + SQ_W;
  localparam int CFG_RANDOM  = 0;
  localparam int CFG_MAX_BOX = 1;
  localparam int CFG_MIN_BOX = 2;

  // first_x/y/z in entries 0..2, second_x/y/z in entries 3..5
  typedef logic [5:0][COORD_W-1:0] pair_t;

  typedef struct packed {
    logic [NUM_LANES-1:0]            wrapped;
    logic [SQ_W-1:0]                 dist_sq;
    logic [NUM_LANES-1:0][SEP_W-1:0] sep;
  } sep_result_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [CFG_W-1:0]  pwdata;
  logic [CFG_W-1:0]  prdata;
  logic              pready;

  // copy of the register file as the block should hold it
  logic [LEN_W-1:0] box_len [NUM_LANES];
  bit               periodic [NUM_LANES];

  sep_result_t expected_seps [$];
  string       axis_name [NUM_LANES] = '{"x", "y", "z"};

  bit gaps_on = 1'b1;
  int hold_cycles = 0;
  int mismatch_count = 0;
  int pair_count = 0;
  int result_count = 0;
  int wrap_count = 0;
  int setting_count = 0;
  int input_stall_cycles = 0;

  minimum_image_separation i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch: %s expected %h got %h", what, want, got);
    end
  endfunction

  // minimum image fold of one axis: subtract round(d/L)*L, halves away from zero
  function automatic void fold_axis(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b,
                                    input logic [LEN_W-1:0] len, input bit per,
                                    output logic [SEP_W-1:0] sep, output bit flag);
    longint            d;
    longint            r;
    longint unsigned   mag;
    longint unsigned   lv;
    longint unsigned   q;
    d = longint'($signed(b)) - longint'($signed(a));
    flag = 1'b0;
    if (!per || len == '0) begin
      sep = SEP_W'(d);
    end else begin
      mag = (d < 0) ? longint'(-d) : d;
      lv  = len;
      q   = (2 * mag + lv) / (2 * lv);
      r   = longint'(mag) - longint'(q * lv);
      flag = (q != 0);
      sep = SEP_W'((d < 0) ? -r : r);
    end
  endfunction

  function automatic sep_result_t predict_separation(pair_t p);
    sep_result_t     res;
    logic [SEP_W-1:0] s;
    bit              f;
    longint          v;
    longint unsigned m;
    logic [SQ_W+1:0] acc;
    acc = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      fold_axis(p[i], p[i+3], box_len[i], periodic[i], s, f);
      res.sep[i] = s;
      res.wrapped[i] = f;
      v = longint'($signed(s));
      m = (v < 0) ? longint'(-v) : v;
      acc += (SQ_W+2)'(m * m);
    end
    res.dist_sq = (acc > {2'b00, {SQ_W{1'b1}}}) ? {SQ_W{1'b1}} : acc[SQ_W-1:0];
    return res;
  endfunction

  function automatic pair_t pair_of(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                    logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
    pair_t p;
    p[0] = ax; p[1] = ay; p[2] = az;
    p[3] = bx; p[4] = by; p[5] = bz;
    return p;
  endfunction

  function automatic logic [COORD_W-1:0] extreme_coord();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // coordinates of one axis, biased toward box multiples and exact halves
  function automatic void random_axis(input int axis, output logic [31:0] a,
                                      output logic [31:0] b);
    longint lv;
    longint k;
    lv = (box_len[axis] == '0) ? 65536 : longint'(box_len[axis]);
    k  = longint'($urandom_range(0, 6)) - 3;
    a  = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: b = $urandom;
      4, 5: b = a + 32'(k * lv) + 32'(longint'($urandom_range(0, 64)) - 32);
      6: b = a + 32'(k * lv) + ($urandom_range(0, 1) ? 32'(lv / 2) : -32'(lv / 2));
      7: b = a + 32'($urandom_range(0, 255)) - 32'd128;
      8: begin
        a = extreme_coord();
        b = extreme_coord();
      end
      default: b = a;
    endcase
  endfunction

  function automatic pair_t random_pair();
    pair_t       p;
    logic [31:0] a;
    logic [31:0] b;
    for (int i = 0; i < NUM_LANES; i++) begin
      random_axis(i, a, b);
      p[i] = a;
      p[i+3] = b;
    end
    return p;
  endfunction

  function automatic logic [LEN_W-1:0] random_box_len();
    case ($urandom_range(0, 3))
      0: return LEN_W'($urandom_range(1, 4096));
      1: return LEN_W'($urandom_range(65536, 1 << 24));
      2: return LEN_W'($urandom_range(1 << 24, 32'h7FFF_FFFF));
      default: return LEN_W'($urandom_range(1, 1 << 20) * 2);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] reg_value(int unsigned idx);
    if (idx <= REG_BOX_Z) return CFG_W'(box_len[idx - REG_BOX_X]);
    return CFG_W'(periodic[idx - REG_PER_X]);
  endfunction

  // all tasks below start and end at a falling edge
  task automatic write_reg(input int unsigned idx, input logic [CFG_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * idx);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_BOX_X, REG_BOX_Y, REG_BOX_Z: box_len[idx - REG_BOX_X] = value[LEN_W-1:0];
      REG_PER_X, REG_PER_Y, REG_PER_Z: periodic[idx - REG_PER_X] = value[0];
      default: ;
    endcase
  endtask

  task automatic read_reg(input int unsigned idx, output logic [CFG_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_W'(4 * idx);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_registers();
    logic [CFG_W-1:0] got;
    for (int i = 0; i < NUM_REGS; i++) begin
      read_reg(i, got);
      if (got !== reg_value(i)) note_mismatch($sformatf("register %0d readback", i),
                                              64'(reg_value(i)), 64'(got));
    end
  endtask

  task automatic set_axis(input int axis, input logic [LEN_W-1:0] len, input bit per);
    write_reg(REG_BOX_X + axis, {1'b0, len});
    write_reg(REG_PER_X + axis, {31'd0, per});
  endtask

  task automatic send_pair(input pair_t p);
    int gap;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 17);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= p;
    do @(posedge clk); while (!s_tready);
    expected_seps.push_back(predict_separation(p));
    pair_count++;
    @(negedge clk);
  endtask

  // stop offering pairs until every pending result is out
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (expected_seps.size() != 0);
  endtask

  task automatic test_reset_defaults();
    check_registers();
    send_pair(pair_of(0, 0, 0, 0, 0, 0));
    send_pair(pair_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_pair(pair_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_pair(pair_of(32'h0001_0000, 32'hFFFF_0000, 0,
                      32'hFFFF_8000, 32'h0002_0000, 32'h0000_0001));
    setting_count++;
  endtask

  task automatic test_half_box();
    wait_for_results();
    set_axis(0, 31'h000A_0000, 1'b1);
    set_axis(1, 31'd1, 1'b1);
    set_axis(2, 31'h7FFF_FFFF, 1'b1);
    check_registers();
    setting_count++;
    // x at plus and minus half a box, then just under it
    send_pair(pair_of(0, 0, 0, 32'h0005_0000, 32'd5, 32'h7FFF_FFFF));
    send_pair(pair_of(32'h0005_0000, 0, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 32'h8000_0000));
    send_pair(pair_of(0, 0, 0, 32'h0004_FFFF, 0, 32'h3FFF_FFFF));
    send_pair(pair_of(32'h1234_0000, 0, 0, 32'h1257_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_pair(pair_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    wait_for_results();
    set_axis(2, 31'h7FFF_FFFE, 1'b1);
    setting_count++;
    send_pair(pair_of(0, 0, 0, 0, 0, 32'h3FFF_FFFF));
    send_pair(pair_of(0, 0, 32'h3FFF_FFFF, 0, 0, 0));
  endtask

  task automatic test_zero_box();
    wait_for_results();
    // zero length keeps the axis unwrapped even with periodic set
    set_axis(0, 31'd0, 1'b1);
    set_axis(1, 31'h0001_0000, 1'b0);
    check_registers();
    setting_count++;
    send_pair(pair_of(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 32'h0004_0000, 32'h0000_8000));
    send_pair(pair_of(32'h0000_0100, 32'hFFFC_0000, 0, 32'hFFFF_0000, 32'h0003_0000, 0));
  endtask

  task automatic test_register_range();
    wait_for_results();
    // writes past the last register must change nothing
    write_reg(NUM_REGS, '1);
    write_reg(NUM_REGS + 1, '1);
    check_registers();
    send_pair(pair_of(32'h0123_4567, 32'h89AB_CDEF, 32'h0F0F_0F0F,
                      32'hFEDC_BA98, 32'h7654_3210, 32'hF0F0_F0F0));
    send_pair(pair_of(32'hFFFF_FFFF, 0, 32'h5555_5555, 0, 32'hFFFF_FFFF, 32'hAAAA_AAAA));
  endtask

  task automatic test_random_phase(input int mode, input int items);
    logic [LEN_W-1:0] len;
    bit               per;
    wait_for_results();
    for (int i = 0; i < NUM_LANES; i++) begin
      case (mode)
        CFG_MAX_BOX: begin
          len = 31'h7FFF_FFFF;
          per = 1'b1;
        end
        CFG_MIN_BOX: begin
          len = 31'd1;
          per = 1'b1;
        end
        default: begin
          len = random_box_len();
          per = ($urandom_range(0, 3) != 0);
        end
      endcase
      // unused upper bits carry noise
      write_reg(REG_BOX_X + i, {1'($urandom_range(0, 1)), len});
      write_reg(REG_PER_X + i, {31'($urandom), per});
    end
    check_registers();
    setting_count++;
    repeat (items) send_pair(random_pair());
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    repeat (130) send_pair(random_pair());
  endtask

  task automatic test_sender_pause();
    repeat (20) send_pair(random_pair());
    wait_for_results();
    repeat (20) send_pair(random_pair());
  endtask

  task automatic test_no_idle();
    gaps_on = 1'b0;
    repeat (60) send_pair(random_pair());
  endtask

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    int n;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        m_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else if (gaps_on && $urandom_range(0, 11) == 0) begin
        n = $urandom_range(1, 17);
        m_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    sep_result_t want;
    if (!rst && s_tvalid && !s_tready) input_stall_cycles++;
    if (!rst && m_tvalid && m_tready) begin
      result_count++;
      if (expected_seps.size() == 0) begin
        note_mismatch("transfer with no pair pending", '0, m_tdata[63:0]);
      end else begin
        want = expected_seps.pop_front();
        for (int i = 0; i < NUM_LANES; i++) begin
          if (m_tdata[i*SEP_W +: SEP_W] !== want.sep[i])
            note_mismatch({axis_name[i], " separation"}, 64'(want.sep[i]),
                          64'(m_tdata[i*SEP_W +: SEP_W]));
          if (m_tdata[WRAP_LSB + i] !== want.wrapped[i])
            note_mismatch({axis_name[i], " wrap flag"}, 64'(want.wrapped[i]),
                          64'(m_tdata[WRAP_LSB + i]));
          if (want.wrapped[i]) wrap_count++;
        end
        if (m_tdata[DIST_LSB +: SQ_W] !== want.dist_sq)
          note_mismatch("squared distance", want.dist_sq, m_tdata[DIST_LSB +: SQ_W]);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results still pending", expected_seps.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      box_len[i] = LEN_RESET;
      periodic[i] = 1'b0;
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_half_box();
    test_zero_box();
    test_register_range();
    test_random_phase(CFG_RANDOM, 75);
    test_random_phase(CFG_MAX_BOX, 60);
    test_random_phase(CFG_RANDOM, 75);
    test_random_phase(CFG_MIN_BOX, 50);
    test_random_phase(CFG_RANDOM, 75);
    test_backpressure();
    test_sender_pause();
    test_no_idle();

    wait_for_results();
    repeat (PIPE_LAT + 20) @(negedge clk);
    if (expected_seps.size() != 0) begin
      mismatch_count += expected_seps.size();
      $display("%0d expected results never arrived", expected_seps.size());
    end
    $display("sent %0d atom pairs, checked %0d results (%0d axis wraps) over %0d box settings",
             pair_count, result_count, wrap_count, setting_count);
    $display("input held back for %0d cycles, %0d mismatches", input_stall_cycles,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
